[rtl/hbb_pkg.sv]
// Shared constants, types and the reciprocal table of the horizontal box blur.
package hbb_pkg;

  localparam int MaxRadius  = 16;
  localparam int WinMax     = 2 * MaxRadius;
  localparam int PixW       = 32;
  localparam int ChanW      = 8;
  localparam int NumChan    = 4;
  localparam int SumW       = 13;
  localparam int PosW       = 6;
  localparam int RadW       = 5;
  localparam int KW         = 4;
  localparam int WinIdxW    = 5;
  localparam int HalfW      = SumW - 1;
  localparam int RecipW     = 18;
  localparam int RecipShift = 17;
  localparam int ProdW      = HalfW + RecipW;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 5;

  localparam logic [CfgIdxW-1:0] CfgRadius    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlurAlpha = 1'b1;

  localparam int ChanAlpha = 3;

  typedef logic [NumChan-1:0][SumW-1:0] sums_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic load;
    logic run_last;
    logic row_done;
  } emit_req_t;

  // ceil(2^17 / r); floor(s * recip >> 17) equals floor(s / r) for s below 4096
  localparam logic [RecipW-1:0] RecipTab [MaxRadius+1] = '{
    18'd0,     18'd131072, 18'd65536, 18'd43691, 18'd32768, 18'd26215,
    18'd21846, 18'd18725,  18'd16384, 18'd14564, 18'd13108, 18'd11916,
    18'd10923, 18'd10083,  18'd9363,  18'd8739,  18'd8192
  };

endpackage

[rtl/hbb_if.sv]
// Valid/ready channels for source pixels and blurred pixels.
interface hbb_in_if;
  import hbb_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            row_end;

  modport source (output valid, output pixel_in, output row_end, input ready);
  modport sink   (input valid, input pixel_in, input row_end, output ready);
endinterface

interface hbb_out_if;
  import hbb_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            run_last;
  logic            row_done;

  modport source (output valid, output pixel_out, output run_last, output row_done,
                  input ready);
  modport sink   (input valid, input pixel_out, input run_last, input row_done,
                  output ready);
endinterface

[rtl/hbb_cell.sv]
// One stage of the pixel history line: loads in parallel or takes its neighbor's pixel.
module hbb_cell (
  input  logic                    clk_i,
  input  hbb_pkg::cell_ctl_t      ctl_i,
  input  logic [hbb_pkg::PixW-1:0] fill_i,
  input  logic [hbb_pkg::PixW-1:0] prev_i,
  output logic [hbb_pkg::PixW-1:0] px_o
);
  import hbb_pkg::*;

  logic [PixW-1:0] px_q, px_d;

  always_comb begin
    px_d = px_q;
    if (ctl_i.load) begin
      px_d = fill_i;
    end else if (ctl_i.shift) begin
      px_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
  end

  assign px_o = px_q;
endmodule

[rtl/hbb_emit.sv]
// Window average by reciprocal multiply and the registered output stage.
module hbb_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hbb_pkg::emit_req_t        req_i,
  input  hbb_pkg::sums_t            sums_i,
  input  logic [hbb_pkg::RadW-1:0]  radius_i,
  input  logic                      alpha_i,
  output logic                      free_o,
  hbb_out_if.source                 out_o
);
  import hbb_pkg::*;

  logic            valid_q, valid_d;
  logic [PixW-1:0] pixel_q, pixel_d;
  logic            run_last_q, run_last_d;
  logic            row_done_q, row_done_d;
  logic [RecipW-1:0] recip;
  logic [NumChan-1:0][ProdW-1:0] prod;
  logic [PixW-1:0] avg_px;

  assign recip = RecipTab[radius_i];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = ProdW'(sums_i[c][SumW-1:1]) * ProdW'(recip);
      avg_px[c*ChanW +: ChanW] = prod[c][RecipShift +: ChanW];
    end
    if (!alpha_i) begin
      avg_px[ChanAlpha*ChanW +: ChanW] = '0;
    end
  end

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d    = valid_q;
    pixel_d    = pixel_q;
    run_last_d = run_last_q;
    row_done_d = row_done_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (req_i.load && free_o) begin
      valid_d    = 1'b1;
      pixel_d    = avg_px;
      run_last_d = req_i.run_last;
      row_done_d = req_i.row_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q    <= pixel_d;
    run_last_q <= run_last_d;
    row_done_q <= row_done_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.pixel_out = pixel_q;
  assign out_o.run_last  = run_last_q;
  assign out_o.row_done  = row_done_q;
endmodule

[rtl/horizontal_box_blur.sv]
// Horizontal box blur with clamped row edges: history cell chain, window sums, sequencer.
// In StEmit the registered sums are averaged and registered once the output is free.
// Input is ready only in StIdle: a pixel with a result holds it through its emit, and a
//   row-end pixel through r - 1 pushes of the last pixel and one emit per pending output.
// Reset: asynchronous, active low; clears the sequencer, row position, output valid
//   and the registers (radius 1, alpha off). History and sums reload at each row start.
module horizontal_box_blur (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hbb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hbb_pkg::CfgDataW-1:0] cfg_data_i,
  hbb_in_if.sink                       in_i,
  hbb_out_if.source                    out_o
);
  import hbb_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEmit = 3'b010,
    StPush = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [RadW-1:0] radius_q, radius_d;
  logic            alpha_q, alpha_d;
  logic [RadW-1:0] row_r_q, row_r_d;
  logic [PosW-1:0] row_pos_q, row_pos_d;
  logic [PosW-1:0] p_q, p_d;
  logic [KW-1:0]   k_q, k_d;
  logic [PixW-1:0] px_q, px_d;
  logic            last_q, last_d;
  sums_t           sums_q, sums_d;

  logic            accept;
  logic            free;
  logic [RadW-1:0] eff_r;
  logic [RadW-1:0] cur_r;
  logic [RadW-1:0] r_m1;
  logic [PosW-1:0] win;
  logic [WinIdxW-1:0] tap_idx;
  logic [PixW-1:0] push_px;
  logic [PixW-1:0] tap_px;
  logic            do_init;
  logic            do_push;
  logic            is_final;
  cell_ctl_t       cell_ctl;
  emit_req_t       emit_req;
  logic [PixW-1:0] cell_px [WinMax];

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    eff_r = radius_q;
    if (radius_q == '0) begin
      eff_r = RadW'(1);
    end else if (radius_q > RadW'(MaxRadius)) begin
      eff_r = RadW'(MaxRadius);
    end
  end

  assign cur_r   = (accept && row_pos_q == '0) ? eff_r : row_r_q;
  assign r_m1    = cur_r - RadW'(1);
  assign win     = {cur_r, 1'b0};
  assign tap_idx = {r_m1[KW-1:0], 1'b1};
  assign tap_px  = cell_px[tap_idx];
  assign push_px = (state_q == StIdle) ? in_i.pixel_in : px_q;
  assign do_init = accept && (row_pos_q == '0);
  assign do_push = (accept && (row_pos_q != '0)) || (state_q == StPush);
  assign is_final = last_q && ({1'b0, k_q} == r_m1);

  assign cell_ctl.load  = do_init;
  assign cell_ctl.shift = do_push;

  for (genvar i = 0; i < WinMax; i++) begin : g_cell
    logic [PixW-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = push_px;
    end else begin : g_link
      assign prev = cell_px[i-1];
    end
    hbb_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .fill_i (in_i.pixel_in),
      .prev_i (prev),
      .px_o   (cell_px[i])
    );
  end

  always_comb begin
    logic [SumW:0] init_prod;
    sums_d = sums_q;
    for (int c = 0; c < NumChan; c++) begin
      init_prod = (SumW+1)'(win) * (SumW+1)'(in_i.pixel_in[c*ChanW +: ChanW]);
      if (do_init) begin
        sums_d[c] = init_prod[SumW-1:0];
      end else if (do_push) begin
        sums_d[c] = sums_q[c] - SumW'(tap_px[c*ChanW +: ChanW])
                              + SumW'(push_px[c*ChanW +: ChanW]);
      end
    end
  end

  always_comb begin
    radius_d = radius_q;
    alpha_d  = alpha_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadius:    radius_d = cfg_data_i;
        CfgBlurAlpha: alpha_d  = cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    row_r_d   = row_r_q;
    row_pos_d = row_pos_q;
    p_d       = p_q;
    k_d       = k_q;
    px_d      = px_q;
    last_d    = last_q;
    emit_req  = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          row_r_d = cur_r;
          p_d     = row_pos_q;
          k_d     = '0;
          px_d    = in_i.pixel_in;
          last_d  = in_i.row_end;
          if (in_i.row_end) begin
            state_d = ({1'b0, row_pos_q} + 7'd1 >= 7'(cur_r)) ? StEmit : StPush;
          end else begin
            if ({1'b0, row_pos_q} + 7'd1 >= 7'(cur_r)) begin
              state_d = StEmit;
            end
            if (row_pos_q < win) begin
              row_pos_d = row_pos_q + PosW'(1);
            end
          end
        end
      end
      StEmit: begin
        emit_req.load     = 1'b1;
        emit_req.run_last = !last_q || is_final;
        emit_req.row_done = is_final;
        if (free) begin
          if (!last_q) begin
            state_d = StIdle;
          end else if (is_final) begin
            state_d   = StIdle;
            row_pos_d = '0;
          end else begin
            state_d = StPush;
          end
        end
      end
      StPush: begin
        k_d = k_q + KW'(1);
        state_d = (7'(p_q) + 7'(k_q) + 7'd2 >= 7'(cur_r)) ? StEmit : StPush;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      radius_q  <= RadW'(1);
      alpha_q   <= 1'b0;
      row_r_q   <= RadW'(1);
      row_pos_q <= '0;
      p_q       <= '0;
      k_q       <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      radius_q  <= radius_d;
      alpha_q   <= alpha_d;
      row_r_q   <= row_r_d;
      row_pos_q <= row_pos_d;
      p_q       <= p_d;
      k_q       <= k_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    sums_q <= sums_d;
  end

  hbb_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (emit_req),
    .sums_i   (sums_q),
    .radius_i (row_r_q),
    .alpha_i  (alpha_q),
    .free_o   (free),
    .out_o    (out_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.row_done |-> out_o.run_last)
    else $error("row_done without run_last");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) && last_q |-> ({1'b0, k_q} < row_r_q))
    else $error("flush count past radius");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_pos_q <= {row_r_q, 1'b0})
    else $error("row position past window");

  a_no_busy_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle) || !$past(in_i.row_end) || (row_pos_q == '0))
    else $error("row end left row position set");
endmodule

[bench/horizontal_box_blur_tb.sv]
// Self-checking bench for the horizontal box blur: directed table, random rows, live predictor.
module horizontal_box_blur_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbb_pkg::*;

  localparam int StallLimit = 3000;
  localparam int RandWords  = 300;
  localparam int ChokeLen   = 400;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [PixW-1:0]     data;
    logic                last;
    logic                typed;
    logic [PixW-1:0]     want;
  } dir_row_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            run_last;
    logic            row_done;
  } blur_word_t;

  localparam dir_row_t DirTab [24] = '{
    '{ROW_PIXEL, CfgRadius,    32'hFFFFFFFF, 1'b1, 1'b1, 32'h00FFFFFF},
    '{ROW_PIXEL, CfgRadius,    32'h00000000, 1'b1, 1'b1, 32'h00000000},
    '{ROW_PIXEL, CfgRadius,    32'h12345678, 1'b0, 1'b1, 32'h00345678},
    '{ROW_PIXEL, CfgRadius,    32'hFFFFFFFF, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, CfgBlurAlpha, 32'h00000001, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'hAABBCCDD, 1'b1, 1'b1, 32'hAABBCCDD},
    '{ROW_PIXEL, CfgRadius,    32'h80808080, 1'b0, 1'b1, 32'h80808080},
    '{ROW_PIXEL, CfgRadius,    32'h01010101, 1'b0, 1'b1, 32'h40404040},
    '{ROW_PIXEL, CfgRadius,    32'h7F7F7F7F, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, CfgRadius,    32'h00000000, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h55AA55AA, 1'b1, 1'b1, 32'h55AA55AA},
    '{ROW_WRITE, CfgRadius,    32'h0000001F, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h00000000, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'hFFFFFFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h0F0F0F0F, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, CfgRadius,    32'h00000002, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h11223344, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, CfgRadius,    32'h00000003, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h99887766, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'hFEDCBA98, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, CfgBlurAlpha, 32'h0000001E, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'hFF000000, 1'b1, 1'b1, 32'h00000000},
    '{ROW_WRITE, CfgRadius,    32'h00000010, 1'b0, 1'b0, 32'h0},
    '{ROW_PIXEL, CfgRadius,    32'h00FFFFFF, 1'b1, 1'b1, 32'h00FFFFFF}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  hbb_in_if  in_if ();
  hbb_out_if out_if ();

  horizontal_box_blur dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state
  logic [PixW-1:0]  hist [WinMax];
  int unsigned      chan_sum [NumChan];
  int unsigned      row_pos;
  int unsigned      row_rad;
  logic [RadW-1:0]  cfg_radius;
  logic             cfg_alpha;
  blur_word_t       pending_blur [$];

  int  mismatches;
  int  words_in;
  int  words_out;
  int  rows_seen;
  int  reg_writes;
  int  send_calm;
  int  idle_cycles;
  bit  choke_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(11))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      2:       return 32'hFF000000;
      3:       return 32'h00FF0000;
      4:       return 32'h0000FF00;
      5:       return 32'h000000FF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RadW-1:0] pick_radius();
    case ($urandom_range(9))
      0:       return 5'd0;
      1:       return 5'd31;
      2:       return 5'd16;
      3:       return 5'd1;
      4:       return RadW'($urandom_range(31));
      default: return RadW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic blur_word_t blur_average(int unsigned win);
    blur_word_t   w;
    int unsigned  v;
    w = '0;
    for (int c = 0; c < NumChan; c++) begin
      v = chan_sum[c] / win;
      if (c == ChanAlpha && !cfg_alpha) v = 0;
      w.pixel[ChanW*c +: ChanW] = v[ChanW-1:0];
    end
    return w;
  endfunction

  task automatic shift_in(input logic [PixW-1:0] px, input int unsigned win);
    logic [PixW-1:0] old;
    old = hist[win-1];
    for (int c = 0; c < NumChan; c++) begin
      chan_sum[c] = chan_sum[c] - old[ChanW*c +: ChanW] + px[ChanW*c +: ChanW];
    end
    for (int i = win - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = px;
  endtask

  task automatic blur_track(input logic [PixW-1:0] px, input logic last);
    int unsigned win;
    int unsigned p;
    int          n;
    blur_word_t  w;
    if (row_pos == 0) begin
      if (cfg_radius == 0) row_rad = 1;
      else if (cfg_radius > MaxRadius) row_rad = MaxRadius;
      else row_rad = cfg_radius;
    end
    win = 2 * row_rad;
    if (row_pos == 0) begin
      for (int i = 0; i < win; i++) hist[i] = px;
      for (int c = 0; c < NumChan; c++) chan_sum[c] = win * px[ChanW*c +: ChanW];
    end else begin
      shift_in(px, win);
    end
    p = row_pos;
    if (!last) begin
      if (p + 1 >= row_rad) begin
        w = blur_average(win);
        w.run_last = 1'b1;
        pending_blur.push_back(w);
      end
      if (row_pos < win) row_pos++;
    end else begin
      n = 0;
      for (int unsigned k = 0; k < row_rad; k++) begin
        if (k > 0) shift_in(px, win);
        if (p + k + 1 >= row_rad) begin
          pending_blur.push_back(blur_average(win));
          n++;
        end
      end
      if (n > 0) begin
        pending_blur[$].run_last = 1'b1;
        pending_blur[$].row_done = 1'b1;
      end
      row_pos = 0;
      for (int c = 0; c < NumChan; c++) chan_sum[c] = 0;
      rows_seen++;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [PixW-1:0] got,
                               input logic [PixW-1:0] want);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic push_word(input logic [PixW-1:0] px, input logic last,
                           input logic typed, input logic [PixW-1:0] want);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(99) < 55) begin
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(99) < 4) send_calm = $urandom_range(15, 60);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.pixel_in <= px;
    in_if.row_end  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    blur_track(px, last);
    if (typed) pending_blur[$].pixel = want;
    words_in++;
    @(negedge clk_i);
  endtask

  // drop the offered word, then wait until every result has left
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_blur.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRadius) cfg_radius = data[RadW-1:0];
    else cfg_alpha = data[0];
    reg_writes++;
    @(negedge clk_i);
  endtask

  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk_i);
      if (choke_req) begin
        choke_req  = 1'b0;
        stall_left = ChokeLen;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(99) < 25) stall_left = pick_gap();
        else if ($urandom_range(99) < 3) calm_left = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    blur_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_out++;
      if (pending_blur.size() == 0) begin
        flag_mismatch("unexpected word", out_if.pixel_out, '0);
      end else begin
        want = pending_blur.pop_front();
        if (out_if.pixel_out !== want.pixel)
          flag_mismatch("pixel_out", out_if.pixel_out, want.pixel);
        if (out_if.run_last !== want.run_last)
          flag_mismatch("run_last", {31'b0, out_if.run_last}, {31'b0, want.run_last});
        if (out_if.row_done !== want.row_done)
          flag_mismatch("row_done", {31'b0, out_if.row_done}, {31'b0, want.row_done});
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d still due",
                 idle_cycles, pending_blur.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int              len;
    int              rand_words;
    int              rand_rows;
    bit              choke_row;
    logic [PixW-1:0] px;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.pixel_in = '0;
    in_if.row_end  = 1'b0;
    out_if.ready   = 1'b0;
    choke_req      = 1'b0;
    mismatches     = 0;
    words_in       = 0;
    words_out      = 0;
    rows_seen      = 0;
    reg_writes     = 0;
    send_calm      = 0;
    rand_words     = 0;
    rand_rows      = 0;
    for (int i = 0; i < WinMax; i++) hist[i] = '0;
    for (int c = 0; c < NumChan; c++) chan_sum[c] = 0;
    row_pos    = 0;
    row_rad    = 1;
    cfg_radius = 5'd1;
    cfg_alpha  = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DirTab); i++) begin
      if (DirTab[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DirTab[i].idx, DirTab[i].data[CfgDataW-1:0]);
      end else begin
        push_word(DirTab[i].data, DirTab[i].last, DirTab[i].typed, DirTab[i].want);
      end
    end

    while (rand_words < RandWords) begin
      choke_row = (rand_rows == 4 || rand_rows == 22);
      if ($urandom_range(3) == 0) begin
        settle();
        write_reg(CfgRadius, pick_radius());
      end
      if ($urandom_range(4) == 0) begin
        settle();
        write_reg(CfgBlurAlpha, CfgDataW'($urandom_range(31)));
      end
      case ($urandom_range(19))
        0:             len = $urandom_range(41, 80);
        1, 2, 3, 4, 5: len = $urandom_range(13, 40);
        default:       len = $urandom_range(1, 12);
      endcase
      if (choke_row) begin
        len       = $urandom_range(30, 50);
        choke_req = 1'b1;
      end
      for (int j = 0; j < len; j++) begin
        if (!choke_row && j == len / 2 && j > 0 && $urandom_range(9) == 0) begin
          settle();
          write_reg(CfgRadius, pick_radius());
        end
        px = pick_pixel();
        push_word(px, j == len - 1, 1'b0, '0);
        rand_words++;
      end
      rand_rows++;
    end
    in_if.valid <= 1'b0;

    while (pending_blur.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("covered %0d source words in %0d rows, %0d register writes, radius 0..31, alpha on/off",
             words_in, rows_seen, reg_writes);
    $display("checked %0d blurred words, %0d mismatches", words_out, mismatches);
    if (mismatches == 0 && pending_blur.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
